// ----- rtl/sbd_pkg.sv -----
// Shared types, constants and helper functions of the script byte descrambler.
`default_nettype none

package sbd_pkg;

	// Header length in bytes and the XOR key applied to the two key bytes.
	localparam int unsigned HDR_LEN = 4;
	localparam logic [7:0] HDR_KEY = 8'hF0;
	localparam logic [7:0] KEY_MASKED = 8'hFF;

	// Number of bytes a group can hold, and the depth of the group queue.
	localparam int unsigned GROUP_MAX = 8;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Reorder kind of a group; PERM_NONE keeps arrival order.
	typedef enum logic [1:0] {
		PERM_2,
		PERM_4,
		PERM_8,
		PERM_NONE
	} perm_t;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		logic [GROUP_MAX-1:0][7:0] bytes;
		logic [2:0]                cnt_m1;
		perm_t                     perm;
		logic                      shuf_en;
		logic [2:0]                row;
		logic                      last;
	} entry_t;

	// Signed bit shifts of each shuffle row.
	localparam int SHIFT_ROWS [8][8] = '{
		'{2,  6, -1,  0,  1, -5, -2, -1},
		'{3,  4,  0,  3, -3,  2, -6, -3},
		'{7,  5,  3,  1, -1, -3, -5, -7},
		'{3,  1, -1, -3,  3,  1, -1, -3},
		'{6,  3, -2,  4, -3, -2, -1, -5},
		'{5,  6,  4, -1, -4, -4, -2, -4},
		'{7, -1,  4, -2, -2, -1, -3, -2},
		'{1,  5, -2, -1,  1,  2, -2, -4}
	};

	// Byte reorder tables for groups of two, four and eight.
	localparam logic [2:0] ORDER_2 [2] = '{3'd1, 3'd0};
	localparam logic [2:0] ORDER_4 [4] = '{3'd2, 3'd3, 3'd0, 3'd1};
	localparam logic [2:0] ORDER_8 [8] = '{3'd6, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2, 3'd0, 3'd3};

	// Moves each bit by its row shift, drops bits shifted out, then inverts.
	function automatic logic [7:0] bit_shuffle(input logic [2:0] row, input logic [7:0] b);
		logic [7:0] acc;
		int         d;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			d = i + SHIFT_ROWS[row][i];
			if (d >= 0 && d < 8) begin
				acc[d[2:0]] = acc[d[2:0]] | b[i];
			end
		end
		return ~acc;
	endfunction

	// Group size in bytes for a reorder kind.
	function automatic logic [3:0] group_size(input perm_t perm);
		logic [3:0] s;
		case (perm)
			PERM_2:  s = 4'd2;
			PERM_4:  s = 4'd4;
			PERM_8:  s = 4'd8;
			default: s = 4'd1;
		endcase
		return s;
	endfunction

	// Buffer slot read for output position k of a group.
	function automatic logic [2:0] order_index(input perm_t perm, input logic [2:0] k);
		logic [2:0] idx;
		case (perm)
			PERM_2:  idx = ORDER_2[k[0]];
			PERM_4:  idx = ORDER_4[k[1:0]];
			PERM_8:  idx = ORDER_8[k];
			default: idx = k;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sbd_front.sv -----
// Front end: parses the header, gathers data bytes into groups, issues queue entries.
`default_nettype none

module sbd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [7:0]      data_byte,
	input  wire logic            first_byte,
	input  wire logic            last_byte,
	input  wire logic            make_readable,
	input  wire logic            q_full,
	output logic                 q_push,
	output sbd_pkg::entry_t      q_entry
);

	logic [2:0]                         hdr_pos_q;
	logic [2:0]                         fill_q;
	logic [2:0]                         row_q;
	logic                               row_valid_q;
	sbd_pkg::perm_t                     perm_q;
	logic [sbd_pkg::GROUP_MAX-1:0][7:0] buf_q;

	logic                               accept;
	logic [2:0]                         hp_eff;
	logic [2:0]                         fill_eff;
	logic                               in_hdr;
	logic [3:0]                         fill_new;
	logic                               complete;
	logic [sbd_pkg::GROUP_MAX-1:0][7:0] merged;
	logic [7:0]                         key;
	sbd_pkg::perm_t                     new_perm;

	assign accept = in_valid && !q_full;

	// A first byte restarts the header and drops any partial group.
	always_comb begin
		hp_eff   = first_byte ? 3'd0 : hdr_pos_q;
		fill_eff = first_byte ? 3'd0 : fill_q;
		in_hdr   = hp_eff < 3'(sbd_pkg::HDR_LEN);
		fill_new = {1'b0, fill_eff} + 4'd1;
		complete = fill_new == sbd_pkg::group_size(perm_q);
		merged   = buf_q;
		merged[fill_eff] = data_byte;
		key      = data_byte ^ sbd_pkg::HDR_KEY;
		case (key)
			8'd0:    new_perm = sbd_pkg::PERM_2;
			8'd1:    new_perm = sbd_pkg::PERM_4;
			8'd2:    new_perm = sbd_pkg::PERM_8;
			default: new_perm = sbd_pkg::PERM_NONE;
		endcase
	end

	// Build the entry: a single header byte, a full group, or a flushed partial group.
	always_comb begin
		q_entry = '0;
		q_entry.last = last_byte;
		if (in_hdr) begin
			q_entry.bytes[0] = (make_readable && (hp_eff == 3'd0 || hp_eff == 3'd1)) ?
				sbd_pkg::KEY_MASKED : data_byte;
			q_entry.cnt_m1   = 3'd0;
			q_entry.perm     = sbd_pkg::PERM_NONE;
			q_entry.shuf_en  = 1'b0;
		end else begin
			q_entry.bytes   = merged;
			q_entry.shuf_en = row_valid_q;
			q_entry.row     = row_q;
			if (complete) begin
				q_entry.cnt_m1 = fill_eff;
				q_entry.perm   = perm_q;
			end else begin
				q_entry.cnt_m1 = fill_eff;
				q_entry.perm   = sbd_pkg::PERM_NONE;
			end
		end
		q_push = accept && (in_hdr || complete || last_byte);
	end

	// Header and group control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			fill_q      <= '0;
			row_q       <= '0;
			row_valid_q <= 1'b1;
			perm_q      <= sbd_pkg::PERM_2;
		end else if (accept) begin
			if (in_hdr) begin
				if (hp_eff == 3'd0) begin
					row_q       <= key[2:0];
					row_valid_q <= key[7:3] == 5'd0;
				end
				if (hp_eff == 3'd1) begin
					perm_q <= new_perm;
				end
				hdr_pos_q <= last_byte ? 3'd0 : hp_eff + 3'd1;
				fill_q    <= '0;
			end else begin
				hdr_pos_q <= last_byte ? 3'd0 : hp_eff;
				fill_q    <= (complete || last_byte) ? 3'd0 : fill_new[2:0];
			end
		end
	end

	// Group buffer; only slots below the fill count are ever used.
	always_ff @(posedge clk) begin
		if (accept && !in_hdr) begin
			buf_q[fill_eff] <= data_byte;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sbd_queue.sv -----
// Short queue of group entries between the front and back ends.
`default_nettype none

module sbd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire sbd_pkg::entry_t wr_entry,
	output logic                 q_full,
	input  wire logic            rd_en,
	output sbd_pkg::entry_t      rd_entry,
	output logic                 q_empty
);

	sbd_pkg::entry_t                    slot_q [sbd_pkg::QUEUE_DEPTH];
	logic [sbd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [sbd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [sbd_pkg::QUEUE_PTR_W:0]      count_q;

	assign q_full   = count_q == (sbd_pkg::QUEUE_PTR_W + 1)'(sbd_pkg::QUEUE_DEPTH);
	assign q_empty  = count_q == '0;
	assign rd_entry = slot_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == (sbd_pkg::QUEUE_PTR_W)'(sbd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == (sbd_pkg::QUEUE_PTR_W)'(sbd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sbd_back.sv -----
// Back end: walks each entry byte by byte, reorders, bit-shuffles and registers the result.
`default_nettype none

module sbd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sbd_pkg::entry_t head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	input  wire logic            pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 out_last
);

	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       load;
	logic       done;
	logic [7:0] raw;
	logic [7:0] shaped;

	// Load the output register when an entry waits and the register is free or being taken this cycle.
	always_comb begin
		load   = !q_empty && (!out_valid_q || pop);
		done   = pos_q == head.cnt_m1;
		q_pop  = load && done;
		raw    = head.bytes[sbd_pkg::order_index(head.perm, pos_q)];
		shaped = head.shuf_en ? sbd_pkg::bit_shuffle(head.row, raw) : raw;
	end

	// Byte position within the head entry and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q       <= done ? 3'd0 : pos_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= shaped;
			out_last_q <= head.last && done;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/script_byte_descrambler_unit.sv -----
// Top level of the script byte descrambler: configuration register, front, queue and back.
//
//  Channel   Signals                                   Direction  Handshake
//  input     push, full, data_byte, first_byte,        in         push & !full
//            last_byte
//  result    empty, pop, out_byte, out_last            out        pop & !empty
//  config    cfg_valid, cfg_ready, cfg_data            in         cfg_valid & cfg_ready
//
// One byte is taken per cycle while full is low; the item that completes a group is
// written to the group queue, and its results leave through the single output register
// of the back end at one byte per cycle while pop is held. A group drains byte by byte.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// The front stalls (full) only while both group queue slots are occupied.
`default_nettype none

module script_byte_descrambler_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	input  wire logic       last_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            out_last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	logic            make_readable_q;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	sbd_pkg::entry_t q_wr_entry;
	sbd_pkg::entry_t q_head;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			make_readable_q <= 1'b0;
		end else if (cfg_valid) begin
			make_readable_q <= cfg_data;
		end
	end

	assign full = q_full;

	sbd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (push),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.make_readable (make_readable_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_wr_entry)
	);

	sbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (q_wr_entry),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_entry (q_head),
		.q_empty  (q_empty)
	);

	sbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	// The front never writes a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group queue written while full");

	// The back never retires an entry from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("group queue read while empty");

	// A waiting result that is not taken keeps its place.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
		else $error("waiting result changed before it was taken");

	// Queue occupancy flags are never both set.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("group queue full and empty at once");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the script byte descrambler: queue-fed driver, checking monitor.
`timescale 1ns / 100ps

module tb;

	// Group modes carried by header byte 1 after the key is removed.
	localparam logic [7:0] MODE_PAIR = 8'd0;
	localparam logic [7:0] MODE_QUAD = 8'd1;
	localparam logic [7:0] MODE_OCT = 8'd2;
	localparam logic [7:0] MODE_PLAIN = 8'd3;

	localparam logic [7:0] KEY_XOR = 8'hF0;
	localparam logic [7:0] MASK_BYTE = 8'hFF;
	localparam int HEADER_BYTES = 4;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 125;

	// Signed bit moves of each shuffle row, and the group reorder tables.
	localparam int ROW_SHIFTS [8][8] = '{
		'{2,  6, -1,  0,  1, -5, -2, -1},
		'{3,  4,  0,  3, -3,  2, -6, -3},
		'{7,  5,  3,  1, -1, -3, -5, -7},
		'{3,  1, -1, -3,  3,  1, -1, -3},
		'{6,  3, -2,  4, -3, -2, -1, -5},
		'{5,  6,  4, -1, -4, -4, -2, -4},
		'{7, -1,  4, -2, -2, -1, -3, -2},
		'{1,  5, -2, -1,  1,  2, -2, -4}
	};
	localparam int SWAP_PAIR [2] = '{1, 0};
	localparam int SWAP_QUAD [4] = '{2, 3, 0, 1};
	localparam int SWAP_OCT [8] = '{6, 4, 5, 7, 1, 2, 0, 3};

	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
	} scr_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} plain_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       last_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;

	script_byte_descrambler_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	scr_byte_t   scrambled_q[$];
	plain_byte_t descrambled_q[$];
	int          err_cnt = 0;

	// Descrambler state as the testbench tracks it.
	logic       readable = 1'b0;
	int         hdr_seen = 0;
	logic [7:0] row_sel = 8'h00;
	logic [7:0] mode_sel = 8'h00;
	logic [7:0] grp [8];
	int         grp_fill = 0;

	// Moves bits by the row shift, drops out-of-byte bits, inverts; rows 8+ pass.
	function automatic logic [7:0] unscramble_bits(input logic [7:0] row, input logic [7:0] b);
		logic [7:0] acc;
		int         d;
		if (row >= 8) begin
			return b;
		end
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			d = i + ROW_SHIFTS[row[2:0]][i];
			if (d >= 0 && d < 8) begin
				acc[d[2:0]] = acc[d[2:0]] | b[i];
			end
		end
		return ~acc;
	endfunction

	function automatic int group_len(input logic [7:0] mode);
		case (mode)
			MODE_PAIR: return 2;
			MODE_QUAD: return 4;
			MODE_OCT: return 8;
			default: return 1;
		endcase
	endfunction

	function automatic int group_slot(input logic [7:0] mode, input int k);
		case (mode)
			MODE_PAIR: return SWAP_PAIR[k];
			MODE_QUAD: return SWAP_QUAD[k];
			MODE_OCT: return SWAP_OCT[k];
			default: return k;
		endcase
	endfunction

	// Works out the bytes that one accepted item releases and queues them.
	function automatic void descramble_item(input logic [7:0] b, input logic first,
			input logic last);
		plain_byte_t r;
		plain_byte_t res[$];
		int          size;
		if (first) begin
			hdr_seen = 0;
			grp_fill = 0;
		end
		if (hdr_seen < HEADER_BYTES) begin
			r.data = b;
			if (hdr_seen == 0) begin
				row_sel = b ^ KEY_XOR;
				if (readable) r.data = MASK_BYTE;
			end else if (hdr_seen == 1) begin
				mode_sel = b ^ KEY_XOR;
				if (readable) r.data = MASK_BYTE;
			end
			hdr_seen++;
			r.last = last;
			res.push_back(r);
		end else begin
			size = group_len(mode_sel);
			grp[grp_fill] = b;
			grp_fill++;
			r.last = 1'b0;
			if (grp_fill >= size) begin
				for (int i = 0; i < size; i++) begin
					r.data = unscramble_bits(row_sel, grp[group_slot(mode_sel, i)]);
					res.push_back(r);
				end
				grp_fill = 0;
			end else if (last) begin
				// A partial or short group leaves in arrival order.
				for (int i = 0; i < grp_fill; i++) begin
					r.data = unscramble_bits(row_sel, grp[i]);
					res.push_back(r);
				end
				grp_fill = 0;
			end
			if (last && res.size() > 0) res[res.size() - 1].last = 1'b1;
		end
		if (last) begin
			hdr_seen = 0;
			grp_fill = 0;
		end
		foreach (res[k]) descrambled_q.push_back(res[k]);
	endfunction

	// Driver: offers items from the pending queue in bursts, usually separated by gaps.
	int        burst_left = 1;
	int        gap_left = 0;
	logic      next_push;
	scr_byte_t drv_it;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				descramble_item(data_byte, first_byte, last_byte);
			end
			if (push && full) begin
				next_push = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				next_push = 1'b0;
			end else if (scrambled_q.size() != 0) begin
				drv_it = scrambled_q.pop_front();
				data_byte <= drv_it.data;
				first_byte <= drv_it.first;
				last_byte <= drv_it.last;
				next_push = 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				next_push = 1'b0;
			end
			push <= next_push;
		end
	end

	// Monitor: checks each accepted result and stalls on a rotating pattern of its own.
	int          results_seen = 0;
	int          hold_left = 0;
	int          pat_age = 0;
	logic [7:0]  pop_pat = 8'hFF;
	logic        next_pop;
	plain_byte_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (descrambled_q.size() == 0) begin
					$error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
					err_cnt++;
				end else begin
					want = descrambled_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						err_cnt++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, out_last);
						err_cnt++;
					end
				end
				results_seen++;
				// One long hold-off so that the block fills and stalls its input.
				if (results_seen == 150) hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_pop = 1'b0;
			end else begin
				if (pat_age == 0) begin
					pop_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
					pat_age = $urandom_range(16, 80);
				end
				pat_age--;
				next_pop = pop_pat[0];
				pop_pat = {pop_pat[0], pop_pat[7:1]};
			end
			pop <= next_pop;
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	task automatic add_item(input logic [7:0] data, input logic first, input logic last);
		scr_byte_t it;
		it.data = data;
		it.first = first;
		it.last = last;
		scrambled_q.push_back(it);
	endtask

	// Writes the make-readable register; only called while the block is idle.
	task automatic write_readable(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		readable = v;
		cfg_valid <= 1'b0;
	endtask

	// Waits until every item is taken and every expected byte has arrived.
	// The check runs at the falling edge, once the rising edge's updates have settled.
	task automatic settle();
		@(negedge clk);
		while (scrambled_q.size() != 0 || push || descrambled_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	bit need_first = 1'b1;
	bit open_file = 1'b0;

	// Adds one file: mostly well formed, sometimes cut short or plain noise.
	task automatic add_random_file();
		int         kind;
		int         len;
		int         total;
		logic [7:0] row;
		logic [7:0] mode;
		logic [7:0] b;
		logic       fst;
		logic       cut;
		kind = $urandom_range(0, 11);
		if (kind == 0) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0);
			end
			need_first = 1'b1;
			open_file = 1'b1;
		end else begin
			cut = (kind == 1);
			fst = need_first || ($urandom_range(0, 3) != 0);
			row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
				: 8'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: mode = MODE_PAIR;
				1: mode = MODE_QUAD;
				2: mode = MODE_OCT;
				default: mode = MODE_PLAIN;
			endcase
			if ($urandom_range(0, 9) == 0) mode = 8'($urandom_range(0, 255));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			total = HEADER_BYTES + len;
			// Now and then the file ends inside its header.
			if ($urandom_range(0, 14) == 0) total = $urandom_range(1, HEADER_BYTES);
			for (int i = 0; i < total; i++) begin
				case (i)
					0: b = KEY_XOR ^ row;
					1: b = KEY_XOR ^ mode;
					default: b = 8'($urandom_range(0, 255));
				endcase
				add_item(b, (i == 0) && fst, (i == total - 1) && !cut);
			end
			need_first = cut;
			open_file = cut;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed files with readable header keys.
		write_readable(1'b1);
		// Row 0, a group of four, then a partial group of one byte flushed by the last marker.
		add_item(KEY_XOR ^ 8'd0, 1'b1, 1'b0);
		add_item(KEY_XOR ^ MODE_QUAD, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(8'h01, 1'b0, 1'b0);
		add_item(8'h80, 1'b0, 1'b0);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hA5, 1'b0, 1'b1);
		// No first marker: the previous last byte restarts the header.
		// A row of 8 or more skips the shuffle; mode 3 passes bytes one at a time.
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(KEY_XOR ^ MODE_PLAIN, 1'b0, 1'b0);
		add_item(8'hAA, 1'b0, 1'b0);
		add_item(8'h55, 1'b0, 1'b0);
		add_item(8'h3C, 1'b0, 1'b0);
		add_item(8'hC3, 1'b0, 1'b1);
		// Groups of eight with a data section shorter than one group.
		add_item(KEY_XOR ^ 8'd6, 1'b1, 1'b0);
		add_item(KEY_XOR ^ MODE_OCT, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'h81, 1'b0, 1'b0);
		add_item(8'h7E, 1'b0, 1'b0);
		add_item(8'hF0, 1'b0, 1'b1);
		// A file that ends inside its header; row 0xF0 is out of the table.
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'hFF, 1'b0, 1'b1);
		settle();

		// Directed files with the header keys passed through.
		write_readable(1'b0);
		// A partial pair is dropped by a first marker in mid-file.
		add_item(KEY_XOR ^ 8'd5, 1'b1, 1'b0);
		add_item(KEY_XOR ^ MODE_PAIR, 1'b0, 1'b0);
		add_item(8'h12, 1'b0, 1'b0);
		add_item(8'h34, 1'b0, 1'b0);
		add_item(8'h0F, 1'b0, 1'b0);
		add_item(8'hF0, 1'b0, 1'b0);
		add_item(8'h99, 1'b0, 1'b0);
		// Row 7, a full group of eight completed by the last byte.
		add_item(KEY_XOR ^ 8'd7, 1'b1, 1'b0);
		add_item(KEY_XOR ^ MODE_OCT, 1'b0, 1'b0);
		add_item(8'h9C, 1'b0, 1'b0);
		add_item(8'h63, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++) begin
			add_item(8'h01 << i, 1'b0, i == 7);
		end
		settle();

		// Random files, flipping the register between phases.
		for (int p = 0; p < 4; p++) begin
			write_readable(p % 2 == 0);
			need_first = 1'b1;
			open_file = 1'b0;
			while (scrambled_q.size() < PHASE_ITEMS || open_file) begin
				add_random_file();
			end
			settle();
		end

		if (descrambled_q.size() != 0) begin
			$error("%0d expected bytes never arrived", descrambled_q.size());
			err_cnt++;
		end
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sbd_pkg.sv
rtl/sbd_front.sv
rtl/sbd_queue.sv
rtl/sbd_back.sv
rtl/script_byte_descrambler_unit.sv
sim/tb.sv
